// ----- hdl/sate_pkg.sv -----
// Package: constants, codes and shared types of the sorted array table engine.
package sate_pkg;

    localparam int DEPTH = 256;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = 32;

    // Command codes
    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_MODIFY = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_LFIND  = 3'd3,
        CMD_BFIND  = 3'd4,
        CMD_SORT   = 3'd5,
        CMD_INSERT = 3'd6,
        CMD_READ   = 3'd7
    } cmd_t;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_DEL       = 3'd2,
        OP_INS       = 3'd3,
        OP_SORT_EVEN = 3'd4,
        OP_SORT_ODD  = 3'd5
    } cell_op_t;

    typedef enum logic {
        SM_POS  = 1'b0,
        SM_FIND = 1'b1
    } scan_mode_t;

    typedef struct packed {
        cell_op_t          op;
        logic [IW-1:0]     pos;
        logic signed [VW-1:0] value;
        logic [CW-1:0]     count;
        scan_mode_t        mode;
        logic [IW:0]       key;
        logic [IW:0]       km1;
        logic [IW:0]       kp1;
    } cell_ctl_t;

    // Scan beat handed from cell to cell toward cell 0
    typedef struct packed {
        logic              hit;
        logic [IW-1:0]     idx;
        logic [VW-1:0]     a;
        logic [VW-1:0]     b;
        logic [VW-1:0]     c;
    } scan_t;

endpackage

// ----- hdl/sate_if.sv -----
// Interfaces: command channel and result channel.
interface sate_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  position;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface sate_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  found_index;
    logic signed [31:0] read_value;
    logic [8:0]  element_count;

    modport source (output valid, output status, output found_index, output read_value,
                    output element_count, input ready);
    modport sink   (input valid, input status, input found_index, input read_value,
                    input element_count, output ready);
endinterface

// ----- hdl/sorted_array_table_engine.sv -----
// Top level: command sequencer over a chain of element cells.
//
//  channel | dir | beat
//  req     | in  | cmd, position, value
//  rsp     | out | status, found_index, read_value, element_count
//
// One command at a time. Read and linear find run a scan that walks the cell chain
// toward cell 0. Binary find and sorted insert run one chain scan per halving step.
// Sort runs odd/even swap passes. Reset clears the count and the handshakes; cell
// contents are undefined until written. A stalled result holds the sequencer until
// rsp is taken.
module sorted_array_table_engine (
    input  logic  clk,
    input  logic  rst_n,
    sate_req_if.sink   req,
    sate_rsp_if.source rsp
);
    import sate_pkg::*;

    localparam int SW = IW + 2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_BS_CHK = 6'b000100,
        S_SORT   = 6'b001000,
        S_DONE   = 6'b010000,
        S_BS_END = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    cell_ctl_t           ctl_reg, ctl_next;
    logic [CW-1:0]       count_reg, count_next;
    cmd_t                cmd_reg, cmd_next;
    logic signed [VW-1:0] tgt_reg, tgt_next;
    logic [CW-1:0]       wait_reg, wait_next;
    logic signed [SW-1:0] lo_reg, lo_next, hi_reg, hi_next, res_reg, res_next;
    status_t             st_reg, st_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [VW-1:0]       rd_reg, rd_next;
    logic                ovalid_reg;
    status_t             ost_reg;
    logic [7:0]          oidx_reg;
    logic [VW-1:0]       ord_reg;
    logic [8:0]          ocnt_reg;

    logic [VW-1:0]       vals [DEPTH];
    scan_t               scans [DEPTH];
    scan_t               scan_head;
    logic                accept, exact;
    logic signed [SW-1:0] mid_s, n_s, sum_s;
    logic [IW-1:0]       mid;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign scan_head = scans[0];
    assign exact = (cmd_reg == CMD_BFIND);

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VW-1:0] lv, rv;
        scan_t         si;
        if (i == 0) begin : g_l0
            assign lv = '0;
        end else begin : g_l
            assign lv = vals[i-1];
        end
        if (i == DEPTH - 1) begin : g_rl
            assign rv = '0;
            assign si = '0;
        end else begin : g_r
            assign rv = vals[i+1];
            assign si = scans[i+1];
        end
        sate_cell u_cell (
            .clk       (clk),
            .idx       (IW'(i)),
            .ctl       (ctl_reg),
            .left_val  (lv),
            .right_val (rv),
            .scan_in   (si),
            .own_val   (vals[i]),
            .scan_out  (scans[i])
        );
    end

    assign n_s   = SW'(count_reg);
    assign mid_s = $signed({{(SW-IW-1){1'b0}}, ctl_reg.key});
    assign sum_s = lo_reg + hi_reg;
    assign mid   = sum_s[IW:1];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ctl_next   = ctl_reg;
        ctl_next.op = OP_HOLD;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        tgt_next   = tgt_reg;
        wait_next  = wait_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        idx_next   = idx_reg;
        rd_next    = rd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_t'(req.cmd);
                    tgt_next   = req.value;
                    st_next    = ST_OK;
                    idx_next   = '0;
                    rd_next    = '0;
                    wait_next  = '0;
                    state_next = S_DONE;
                    ctl_next.value = req.value;
                    ctl_next.count = count_reg;
                    lo_next    = '0;
                    hi_next    = n_s - SW'(1);
                    res_next   = (cmd_t'(req.cmd) == CMD_BFIND) ? '1 : '0;
                    if (cmd_t'(req.cmd) == CMD_APPEND || cmd_t'(req.cmd) == CMD_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                            st_next = ST_FULL;
                        else if (cmd_t'(req.cmd) == CMD_APPEND)
                        begin
                            ctl_next.op  = OP_WRITE;
                            ctl_next.pos = IW'(count_reg);
                            idx_next     = IW'(count_reg);
                            count_next   = count_reg + CW'(1);
                        end
                        else
                            state_next = S_BS_CHK;
                    end
                    else if (count_reg == '0)
                        st_next = ST_EMPTY;
                    else
                    begin
                        case (cmd_t'(req.cmd))
                            CMD_MODIFY, CMD_DELETE, CMD_READ:
                            begin
                                if (CW'(req.position) >= count_reg)
                                    st_next = ST_BADPOS;
                                else
                                begin
                                    idx_next     = IW'(req.position);
                                    ctl_next.pos = IW'(req.position);
                                    ctl_next.key = {1'b0, IW'(req.position)};
                                    ctl_next.mode = SM_POS;
                                    if (cmd_t'(req.cmd) == CMD_MODIFY)
                                        ctl_next.op = OP_WRITE;
                                    else if (cmd_t'(req.cmd) == CMD_DELETE)
                                    begin
                                        ctl_next.op = OP_DEL;
                                        count_next  = count_reg - CW'(1);
                                    end
                                    else
                                        state_next = S_SCAN;
                                end
                            end
                            CMD_LFIND:
                            begin
                                ctl_next.mode = SM_FIND;
                                state_next    = S_SCAN;
                            end
                            CMD_BFIND: state_next = S_BS_CHK;
                            default:
                            begin
                                ctl_next.op = OP_SORT_EVEN;
                                state_next  = S_SORT;
                            end
                        endcase
                    end
                end
            end
            S_BS_CHK:
            begin
                if (lo_reg <= hi_reg)
                begin
                    ctl_next.mode = SM_POS;
                    ctl_next.key  = {1'b0, mid};
                    ctl_next.km1  = {1'b0, mid} - (IW+1)'(1);
                    ctl_next.kp1  = {1'b0, mid} + (IW+1)'(1);
                    wait_next     = '0;
                    state_next    = S_SCAN;
                end
                else
                    state_next = S_BS_END;
            end
            S_BS_END:
            begin
                // Halving search finished: res holds match or slot
                state_next = S_DONE;
                if (exact)
                begin
                    if (res_reg < 0)
                        st_next = ST_NOTFOUND;
                    else
                        idx_next = IW'(res_reg);
                end
                else
                begin
                    ctl_next.op  = OP_INS;
                    ctl_next.pos = IW'(res_reg);
                    idx_next     = IW'(res_reg);
                    count_next   = count_reg + CW'(1);
                end
            end
            S_SCAN:
            begin
                wait_next = wait_reg + CW'(1);
                if (wait_reg == CW'(DEPTH))
                begin
                    state_next = S_DONE;
                    case (cmd_reg)
                        CMD_READ: rd_next = scan_head.a;
                        CMD_LFIND:
                        begin
                            if (scan_head.hit)
                                idx_next = scan_head.idx;
                            else
                                st_next = ST_NOTFOUND;
                        end
                        default:
                        begin
                            state_next = S_BS_CHK;
                            if ($signed(scan_head.a) == tgt_reg)
                            begin
                                res_next = mid_s;
                                lo_next  = mid_s + SW'(1);
                            end
                            else if ($signed(scan_head.a) > tgt_reg)
                            begin
                                lo_next = mid_s + SW'(1);
                                if (!exact && ((mid_s + SW'(1) >= n_s)
                                    || ($signed(scan_head.c) < tgt_reg)))
                                begin
                                    res_next   = mid_s + SW'(1);
                                    state_next = S_BS_END;
                                end
                            end
                            else
                            begin
                                hi_next = mid_s - SW'(1);
                                if (!exact && ((mid_s == '0)
                                    || ($signed(scan_head.b) > tgt_reg)))
                                begin
                                    res_next   = mid_s;
                                    state_next = S_BS_END;
                                end
                            end
                        end
                    endcase
                end
            end
            S_SORT:
            begin
                wait_next = wait_reg + CW'(1);
                if (wait_reg == CW'(DEPTH - 1))
                    state_next = S_DONE;
                else
                    ctl_next.op = wait_reg[0] ? OP_SORT_EVEN : OP_SORT_ODD;
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // Cells always see the count that follows this cycle
        ctl_next.count = count_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ctl_reg    <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ctl_reg    <= ctl_next;
            count_reg  <= count_next;
            if (state_reg == S_DONE && (!ovalid_reg || rsp.ready))
                ovalid_reg <= 1'b1;
            else if (rsp.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tgt_reg  <= tgt_next;
        wait_reg <= wait_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        idx_reg  <= idx_next;
        rd_reg   <= rd_next;
        if (state_reg == S_DONE && (!ovalid_reg || rsp.ready))
        begin
            ost_reg  <= st_reg;
            oidx_reg <= 8'(idx_reg);
            ord_reg  <= rd_reg;
            ocnt_reg <= 9'(count_reg);
        end
    end

    assign rsp.valid         = ovalid_reg;
    assign rsp.status        = ost_reg;
    assign rsp.found_index   = oidx_reg;
    assign rsp.read_value    = ord_reg;
    assign rsp.element_count = ocnt_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("ready right after accept");
    a_idle_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg == S_IDLE)) |-> ctl_reg.op == OP_HOLD)
        else $error("cell operation while idle");
endmodule

// ----- hdl/sate_cell.sv -----
// One storage cell: holds an element, shifts and swaps with neighbors, forwards scans.
module sate_cell (
    input  logic                    clk,
    input  logic [sate_pkg::IW-1:0] idx,
    input  sate_pkg::cell_ctl_t     ctl,
    input  logic [sate_pkg::VW-1:0] left_val,
    input  logic [sate_pkg::VW-1:0] right_val,
    input  sate_pkg::scan_t         scan_in,
    output logic [sate_pkg::VW-1:0] own_val,
    output sate_pkg::scan_t         scan_out
);
    import sate_pkg::*;

    logic [VW-1:0] val_reg, val_next;
    scan_t         scan_reg, scan_next;
    logic          in_cnt, nb_in_cnt, par, hit_a, hit_b, hit_c;
    logic [IW:0]   idx_x;

    assign idx_x     = {1'b0, idx};
    assign in_cnt    = CW'(idx) < ctl.count;
    assign nb_in_cnt = (CW'(idx) + CW'(1)) < ctl.count;
    assign par       = (ctl.op == OP_SORT_ODD);

    // Element update
    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            OP_WRITE:
            begin
                if (idx == ctl.pos) val_next = ctl.value;
            end
            OP_DEL:
            begin
                if (idx >= ctl.pos) val_next = right_val;
            end
            OP_INS:
            begin
                if (idx > ctl.pos) val_next = left_val;
                else if (idx == ctl.pos) val_next = ctl.value;
            end
            OP_SORT_EVEN, OP_SORT_ODD:
            begin
                if (idx[0] == par)
                begin
                    if (nb_in_cnt && ($signed(val_reg) < $signed(right_val)))
                        val_next = right_val;
                end
                else if (idx != '0 && in_cnt && ($signed(left_val) < $signed(val_reg)))
                begin
                    val_next = left_val;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    // Scan stage: nearest hit toward cell 0 wins
    always_comb
    begin
        hit_a = (ctl.mode == SM_FIND) ? (($signed(val_reg) == ctl.value) && in_cnt)
                                      : (idx_x == ctl.key);
        hit_b = (idx_x == ctl.km1);
        hit_c = (idx_x == ctl.kp1);
        scan_next.hit = hit_a | scan_in.hit;
        scan_next.idx = hit_a ? idx : scan_in.idx;
        scan_next.a   = hit_a ? val_reg : scan_in.a;
        scan_next.b   = hit_b ? val_reg : scan_in.b;
        scan_next.c   = hit_c ? val_reg : scan_in.c;
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        scan_reg <= scan_next;
    end

    assign own_val  = val_reg;
    assign scan_out = scan_reg;

endmodule

// ----- sim/sate_table_checker.sv -----
// Checker: watches both channels, predicts each result and compares it field by field.
module sate_table_checker (
    input  logic  clk,
    input  logic  rst_n,
    sate_req_if   req,
    sate_rsp_if   rsp,
    output int    mismatches,
    output int    pending
);
    import sate_pkg::*;

    typedef struct {
        status_t              status;
        logic [7:0]           found_index;
        logic signed [31:0]   read_value;
        logic [8:0]           element_count;
    } table_result_t;

    // Mirror of the table contents
    logic signed [31:0] table_vals [DEPTH];
    int                 table_count;
    table_result_t      expected_results [$];

    initial
    begin
        mismatches  = 0;
        table_count = 0;
    end

    assign pending = expected_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Halving search over a descending table; exact gives last match or -1,
    // otherwise the slot that keeps the order
    function automatic int halving_search(input logic signed [31:0] target, input bit exact);
        int n;
        int lo;
        int hi;
        int mid;
        int res;
        logic signed [31:0] e;
        n   = table_count;
        lo  = 0;
        hi  = n - 1;
        res = exact ? -1 : 0;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            e   = table_vals[mid];
            if (e == target)
            begin
                res = mid;
                lo  = mid + 1;
            end
            else if (e > target)
            begin
                lo = mid + 1;
                if (!exact)
                begin
                    if (mid + 1 >= n) return mid + 1;
                    if (table_vals[mid + 1] < target) return mid + 1;
                end
            end
            else
            begin
                hi = mid - 1;
                if (!exact)
                begin
                    if (mid - 1 < 0) return mid;
                    if (table_vals[mid - 1] > target) return mid;
                end
            end
        end
        return res;
    endfunction

    // Apply one command to the mirror and queue its result
    task automatic apply_command(input cmd_t c, input logic [7:0] p,
                                 input logic signed [31:0] v);
        table_result_t r;
        int slot;
        int j;
        logic signed [31:0] key;
        r.status     = ST_OK;
        r.found_index = '0;
        r.read_value = '0;
        if (c == CMD_APPEND || c == CMD_INSERT)
        begin
            if (table_count >= DEPTH)
                r.status = ST_FULL;
            else if (c == CMD_APPEND)
            begin
                r.found_index = table_count[7:0];
                table_vals[table_count] = v;
                table_count++;
            end
            else
            begin
                slot = halving_search(v, 1'b0);
                for (j = table_count; j > slot; j--)
                    table_vals[j] = table_vals[j - 1];
                table_vals[slot] = v;
                table_count++;
                r.found_index = slot[7:0];
            end
        end
        else if (table_count == 0)
            r.status = ST_EMPTY;
        else if (c == CMD_MODIFY || c == CMD_DELETE || c == CMD_READ)
        begin
            if (int'(p) >= table_count)
                r.status = ST_BADPOS;
            else
            begin
                r.found_index = p;
                if (c == CMD_MODIFY)
                    table_vals[p] = v;
                else if (c == CMD_DELETE)
                begin
                    for (j = p; j + 1 < table_count; j++)
                        table_vals[j] = table_vals[j + 1];
                    table_count--;
                end
                else
                    r.read_value = table_vals[p];
            end
        end
        else if (c == CMD_LFIND)
        begin
            r.status = ST_NOTFOUND;
            for (j = 0; j < table_count; j++)
            begin
                if (table_vals[j] == v)
                begin
                    r.status      = ST_OK;
                    r.found_index = j[7:0];
                    break;
                end
            end
        end
        else if (c == CMD_BFIND)
        begin
            slot = halving_search(v, 1'b1);
            if (slot >= 0)
                r.found_index = slot[7:0];
            else
                r.status = ST_NOTFOUND;
        end
        else
        begin
            // insertion sort, descending
            for (int i = 1; i < table_count; i++)
            begin
                key = table_vals[i];
                j = i;
                while (j > 0 && table_vals[j - 1] < key)
                begin
                    table_vals[j] = table_vals[j - 1];
                    j--;
                end
                table_vals[j] = key;
            end
        end
        r.element_count = table_count[8:0];
        expected_results.push_back(r);
    endtask

    // Predict on accepted commands, then check accepted results
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                apply_command(cmd_t'(req.cmd), req.position, req.value);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected result beat", 32'(rsp.status), 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                        report("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.found_index !== want.found_index)
                        report("found_index", 32'(rsp.found_index), 32'(want.found_index));
                    if (rsp.read_value !== want.read_value)
                        report("read_value", rsp.read_value, want.read_value);
                    if (rsp.element_count !== want.element_count)
                        report("element_count", 32'(rsp.element_count),
                               32'(want.element_count));
                end
            end
        end
    end

endmodule

// ----- sim/sorted_array_table_engine_test.sv -----
// Testbench top: clock, reset, command stimulus, result-side stalls and the verdict.
module sorted_array_table_engine_test;
    import sate_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 20_000_000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   gap_pct;
    int   stall_pct;
    int   hold_off;
    int   table_size;
    int   cycles;

    sate_req_if req_ch ();
    sate_rsp_if rsp_ch ();

    sorted_array_table_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    sate_table_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Known input values and reset
    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_APPEND;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        gap_pct         = 0;
        stall_pct       = 0;
        hold_off        = 0;
        rst_n           = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sorted_array_table_engine_test NOT OK");
        $finish;
    end

    // Offer one command and wait for it to be taken; tracks the table size
    task automatic send_cmd(input cmd_t c, input logic [7:0] p, input logic signed [31:0] v);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.position <= p;
        req_ch.value    <= v;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        if ((c == CMD_APPEND || c == CMD_INSERT) && table_size < DEPTH)
            table_size++;
        else if (c == CMD_DELETE && int'(p) < table_size)
            table_size--;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(16)) - 8;
        endcase
    endfunction

    function automatic logic [7:0] pick_position();
        if (table_size > 0 && $urandom_range(99) < 80)
            return 8'($urandom_range(table_size - 1));
        return 8'($urandom_range(255));
    endfunction

    // Random command, weighted so the table grows a little on average
    task automatic send_random();
        int roll;
        roll = $urandom_range(99);
        if (roll < 22)      send_cmd(CMD_APPEND, 8'($urandom), pick_value());
        else if (roll < 40) send_cmd(CMD_INSERT, 8'($urandom), pick_value());
        else if (roll < 50) send_cmd(CMD_MODIFY, pick_position(), pick_value());
        else if (roll < 64) send_cmd(CMD_DELETE, pick_position(), pick_value());
        else if (roll < 74) send_cmd(CMD_LFIND, 8'($urandom), pick_value());
        else if (roll < 84) send_cmd(CMD_BFIND, 8'($urandom), pick_value());
        else if (roll < 89) send_cmd(CMD_SORT, 8'($urandom), $urandom);
        else                send_cmd(CMD_READ, pick_position(), $urandom);
    endtask

    // Stimulus and verdict
    initial
    begin
        int n;
        table_size = 0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: empty table, extremes, every command
        send_cmd(CMD_READ,   8'd0,   32'sd0);
        send_cmd(CMD_DELETE, 8'd0,   32'sd0);
        send_cmd(CMD_MODIFY, 8'd0,   32'sd5);
        send_cmd(CMD_LFIND,  8'd0,   32'sd0);
        send_cmd(CMD_BFIND,  8'd0,   32'sd0);
        send_cmd(CMD_SORT,   8'd0,   32'sd0);
        send_cmd(CMD_APPEND, 8'hff,  32'sh80000000);
        send_cmd(CMD_APPEND, 8'h00,  32'sh7fffffff);
        send_cmd(CMD_APPEND, 8'h55,  32'sd3);
        send_cmd(CMD_APPEND, 8'haa,  32'sd3);
        send_cmd(CMD_READ,   8'd1,   32'sd0);
        send_cmd(CMD_READ,   8'd255, 32'sd0);
        send_cmd(CMD_MODIFY, 8'd2,   -32'sd1);
        send_cmd(CMD_MODIFY, 8'd4,   32'sd9);
        send_cmd(CMD_LFIND,  8'd0,   32'sd3);
        send_cmd(CMD_LFIND,  8'd0,   32'sd77);
        send_cmd(CMD_BFIND,  8'd0,   32'sd3);
        send_cmd(CMD_SORT,   8'd0,   32'sd0);
        send_cmd(CMD_BFIND,  8'd0,   32'sd3);
        send_cmd(CMD_BFIND,  8'd0,   32'sd4);
        send_cmd(CMD_INSERT, 8'd0,   32'sd3);
        send_cmd(CMD_INSERT, 8'd0,   32'sh7fffffff);
        send_cmd(CMD_INSERT, 8'd0,   32'sh80000000);
        send_cmd(CMD_DELETE, 8'd0,   32'sd0);
        send_cmd(CMD_DELETE, 8'd200, 32'sd0);

        // Random part, idling phases rotate every 150 commands
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ((i / 150) % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                default: begin gap_pct = 10; stall_pct = 10; end
            endcase
            if (i == 310)
                hold_off = 3000;
            if (i == 500)
            begin
                // Fill to full, with finds and sorts on the way, then overflow
                n = 0;
                while (table_size < DEPTH || n < 6)
                begin
                    if (table_size == DEPTH) n++;
                    if ($urandom_range(9) == 0) send_random();
                    else send_cmd($urandom_range(1) ? CMD_APPEND : CMD_INSERT,
                                  8'($urandom), pick_value());
                end
                send_cmd(CMD_SORT, 8'd0, 32'sd0);
                send_cmd(CMD_READ, 8'd255, 32'sd0);
            end
            else if (i == 900)
            begin
                // Drain to empty, then exercise the empty table
                while (table_size > 0)
                    send_cmd(CMD_DELETE, 8'($urandom_range(table_size - 1)), $urandom);
                for (int k = 0; k < 8; k++)
                    send_cmd(cmd_t'(3'($urandom_range(7))), 8'($urandom), pick_value());
            end
            else
                send_random();
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding results
        gap_pct   = 0;
        stall_pct = 0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("sorted_array_table_engine_test OK");
        else
            $display("sorted_array_table_engine_test NOT OK");
        $finish;
    end

endmodule
